// ----- design/spra_pkg.sv -----
`default_nettype none
package spra_pkg;

  localparam int DIST_W = 20;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam int FRAC_BITS = 4;
  localparam int CFG_W = 8;
  localparam logic [CFG_W-1:0] US_PER_CM_RESET = 8'd58;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_SINGLE = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_US_PER_CM   = 1'b0,
    REG_TRIGGER_PIN = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_REPORT,
    OP_STORE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic trig;
    logic done;
  } job_ctl_t;

  localparam int JOB_CTL_W = $bits(job_ctl_t);

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_Q,
    BK_WR,
    BK_AVG,
    BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

// ----- design/spra_queue.sv -----
`default_nettype none
module spra_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         rd,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_wr;
  logic         do_rd;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) begin
        mem[wp] <= wdata;
        wp      <= !wp;
      end
      if (do_rd) begin
        rp <= !rp;
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/spra_front.sv -----
`default_nettype none
module spra_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [1:0]            cmd,
  input  wire logic                  echo_level,
  input  wire logic                  trigger_pin,
  input  wire logic                  q_full,
  output logic                       job_push,
  output spra_pkg::job_ctl_t         job_ctl,
  output logic [COUNT_BITS-1:0]      job_count
);

  logic                  prev_echo;
  logic                  prev_echo_next;
  logic [COUNT_BITS-1:0] pulse_count;
  logic [COUNT_BITS-1:0] pulse_count_next;
  logic                  single_mode;
  logic                  single_mode_next;
  logic                  trigger_out;
  logic                  trigger_out_next;

  assign job_push = push && !q_full;

  always_comb begin
    prev_echo_next   = prev_echo;
    pulse_count_next = pulse_count;
    single_mode_next = single_mode;
    trigger_out_next = trigger_out;
    job_ctl.op       = spra_pkg::OP_REPORT;
    job_ctl.done     = 1'b0;
    unique case (spra_pkg::cmd_t'(cmd))
      spra_pkg::CMD_TICK: begin
        if (echo_level && !prev_echo) begin
          pulse_count_next = '0;
        end else if (prev_echo) begin
          if (pulse_count != '1) begin
            pulse_count_next = pulse_count + COUNT_BITS'(1);
          end
          if (!echo_level) begin
            job_ctl.op   = spra_pkg::OP_STORE;
            job_ctl.done = 1'b1;
            if (single_mode && trigger_pin) begin
              trigger_out_next = 1'b0;
            end
          end
        end
        prev_echo_next = echo_level;
      end
      spra_pkg::CMD_START: begin
        if (trigger_pin) trigger_out_next = 1'b1;
      end
      spra_pkg::CMD_STOP: begin
        if (trigger_pin) trigger_out_next = 1'b0;
      end
      spra_pkg::CMD_SINGLE: begin
        if (trigger_pin) begin
          job_ctl.op       = spra_pkg::OP_CLEAR;
          single_mode_next = 1'b1;
          trigger_out_next = 1'b1;
        end
      end
      default: ;
    endcase
    job_ctl.trig = trigger_out_next;
    job_count    = pulse_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_echo   <= 1'b0;
      pulse_count <= '0;
      single_mode <= 1'b0;
      trigger_out <= 1'b0;
    end else if (job_push) begin
      prev_echo   <= prev_echo_next;
      pulse_count <= pulse_count_next;
      single_mode <= single_mode_next;
      trigger_out <= trigger_out_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/spra_div.sv -----
`default_nettype none
module spra_div #(
  parameter int DW = 23,
  parameter int VW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial    = {rem, quo[DW-1]};
  assign ge       = (trial >= {1'b0, dvs});
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && !start && (cnt == CW'(1));
      if (start) begin
        quo     <= dividend;
        rem     <= '0;
        dvs     <= divisor;
        cnt     <= CW'(DW);
        running <= 1'b1;
      end else if (running) begin
        rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/spra_back.sv -----
`default_nettype none
module spra_back #(
  parameter int HISTORY_DEPTH = 5,
  parameter int COUNT_BITS    = 16,
  parameter int DIV_W         = 20
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         job_empty,
  input  wire spra_pkg::job_ctl_t           job_ctl,
  input  wire logic [COUNT_BITS-1:0]        job_count,
  output logic                              job_pop,
  input  wire logic [spra_pkg::CFG_W-1:0]   us_per_cm,
  output logic                              div_start,
  output logic [DIV_W-1:0]                  div_dividend,
  output logic [spra_pkg::CFG_W-1:0]        div_divisor,
  input  wire logic                         div_done,
  input  wire logic [DIV_W-1:0]             div_quotient,
  input  wire logic                         pop,
  output logic                              out_valid,
  output logic [spra_pkg::DIST_W-1:0]       distance_q4,
  output logic                              trigger_level,
  output logic                              reading_done
);

  localparam int LOG_D    = $clog2(HISTORY_DEPTH);
  localparam int SUM_W    = spra_pkg::DIST_W + LOG_D;
  localparam int RECIP_SH = SUM_W + LOG_D;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SH)
      + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  spra_pkg::bk_state_t         state;
  spra_pkg::bk_state_t         state_next;
  spra_pkg::job_ctl_t          ctl;
  logic [spra_pkg::DIST_W-1:0] ring [HISTORY_DEPTH];
  logic [IDX_W-1:0]            ring_index;
  logic [SUM_W-1:0]            sum;
  logic                        single_mode;
  logic [spra_pkg::DIST_W-1:0] dist_cur;
  logic [spra_pkg::DIST_W-1:0] qv;
  logic [spra_pkg::DIST_W-1:0] q_sat;
  logic [PROD_W-1:0]           avg_prod;
  logic                        out_free;

  assign out_free = !out_valid || pop;
  assign q_sat = (div_quotient > DIV_W'(spra_pkg::DIST_MAX)) ? spra_pkg::DIST_MAX
               : div_quotient[spra_pkg::DIST_W-1:0];
  // ring average by reciprocal multiplication, exact over the whole sum range
  assign avg_prod = PROD_W'(sum) * PROD_W'(RECIP);

  always_comb begin
    state_next = state;
    unique case (state)
      spra_pkg::BK_IDLE: begin
        if (!job_empty) begin
          state_next = (job_ctl.op == spra_pkg::OP_STORE) ? spra_pkg::BK_DIV_Q
                     : spra_pkg::BK_OUT;
        end
      end
      spra_pkg::BK_DIV_Q: if (div_done) state_next = spra_pkg::BK_WR;
      spra_pkg::BK_WR:    state_next = spra_pkg::BK_AVG;
      spra_pkg::BK_AVG:   state_next = spra_pkg::BK_OUT;
      spra_pkg::BK_OUT:   if (out_free) state_next = spra_pkg::BK_IDLE;
      default:            state_next = spra_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop      = (state == spra_pkg::BK_IDLE) && !job_empty;
    div_start    = job_pop && (job_ctl.op == spra_pkg::OP_STORE);
    div_dividend = DIV_W'({job_count, spra_pkg::FRAC_BITS'(0)});
    div_divisor  = (us_per_cm == '0) ? spra_pkg::CFG_W'(1) : us_per_cm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= spra_pkg::BK_IDLE;
      ring_index  <= '0;
      sum         <= '0;
      single_mode <= 1'b0;
      dist_cur    <= '0;
      out_valid   <= 1'b0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        ring[k] <= '0;
      end
    end else begin
      state <= state_next;
      if ((state == spra_pkg::BK_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        spra_pkg::BK_IDLE: begin
          if (!job_empty) begin
            ctl <= job_ctl;
            if (job_ctl.op == spra_pkg::OP_CLEAR) begin
              for (int k = 0; k < HISTORY_DEPTH; k++) begin
                ring[k] <= '0;
              end
              ring_index  <= '0;
              sum         <= '0;
              single_mode <= 1'b1;
              dist_cur    <= '0;
            end
          end
        end
        spra_pkg::BK_DIV_Q: if (div_done) qv <= q_sat;
        spra_pkg::BK_WR: begin
          ring[ring_index] <= qv;
          sum <= sum - SUM_W'(ring[ring_index]) + SUM_W'(qv);
          ring_index <= (ring_index == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                      : ring_index + IDX_W'(1);
        end
        spra_pkg::BK_AVG: begin
          if (single_mode) begin
            dist_cur <= ring[0];
          end else begin
            dist_cur <= avg_prod[RECIP_SH +: spra_pkg::DIST_W];
          end
        end
        spra_pkg::BK_OUT: begin
          if (out_free) begin
            distance_q4   <= dist_cur;
            trigger_level <= ctl.trig;
            reading_done  <= ctl.done;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/sonar_pulse_range_averager.sv -----
// items that store no reading pass from the job queue through the back-end IDLE and OUT states
// the two-entry job queue accepts new items while the back end is still busy, until it is full
// a falling echo edge stores a reading: the bit-serial divide by us_per_cm, then BK_WR,
// BK_AVG and BK_OUT, with DIV_W = max(COUNT_BITS+4, 20)
// reset: synchronous, clears config to defaults, history ring, counters and queues
`default_nettype none
module sonar_pulse_range_averager #(
  parameter int HISTORY_DEPTH = 5,
  parameter int COUNT_BITS    = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 cmd,
  input  wire logic                       echo_level,
  input  wire logic                       pop,
  output logic                            empty,
  output logic [spra_pkg::DIST_W-1:0]     distance_q4,
  output logic                            trigger_level,
  output logic                            reading_done,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [spra_pkg::CFG_W-1:0] cfg_data
);

  localparam int NUM_W = COUNT_BITS + spra_pkg::FRAC_BITS;
  localparam int DIV_W = (NUM_W > spra_pkg::DIST_W) ? NUM_W : spra_pkg::DIST_W;
  localparam int JW    = spra_pkg::JOB_CTL_W + COUNT_BITS;

  logic [spra_pkg::CFG_W-1:0] us_per_cm;
  logic                       trigger_pin;
  logic                       job_push;
  spra_pkg::job_ctl_t         push_ctl;
  logic [COUNT_BITS-1:0]      push_count;
  logic                       job_full;
  logic                       job_empty;
  logic                       job_pop;
  logic [JW-1:0]              job_data;
  logic                       div_start;
  logic [DIV_W-1:0]           div_dividend;
  logic [spra_pkg::CFG_W-1:0] div_divisor;
  logic                       div_done;
  logic [DIV_W-1:0]           div_quotient;
  logic                       out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      us_per_cm   <= spra_pkg::US_PER_CM_RESET;
      trigger_pin <= 1'b0;
    end else if (cfg_we) begin
      unique case (spra_pkg::reg_idx_t'(cfg_index))
        spra_pkg::REG_US_PER_CM:   us_per_cm   <= cfg_data;
        spra_pkg::REG_TRIGGER_PIN: trigger_pin <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign full  = job_full;
  assign empty = !out_valid;

  spra_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .cmd        (cmd),
    .echo_level (echo_level),
    .trigger_pin(trigger_pin),
    .q_full     (job_full),
    .job_push   (job_push),
    .job_ctl    (push_ctl),
    .job_count  (push_count)
  );

  spra_queue #(
    .W(JW)
  ) u_job_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (job_push),
    .wdata({push_ctl, push_count}),
    .full (job_full),
    .rd   (job_pop),
    .rdata(job_data),
    .empty(job_empty)
  );

  spra_div #(
    .DW(DIV_W),
    .VW(spra_pkg::CFG_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quotient)
  );

  spra_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .COUNT_BITS   (COUNT_BITS),
    .DIV_W        (DIV_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_empty    (job_empty),
    .job_ctl      (spra_pkg::job_ctl_t'(job_data[JW-1 -: spra_pkg::JOB_CTL_W])),
    .job_count    (job_data[COUNT_BITS-1:0]),
    .job_pop      (job_pop),
    .us_per_cm    (us_per_cm),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .pop          (pop),
    .out_valid    (out_valid),
    .distance_q4  (distance_q4),
    .trigger_level(trigger_level),
    .reading_done (reading_done)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("back end took a job from an empty queue");

  a_div_single_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_start && !div_done)
    else $error("divider restarted or finished too early");

endmodule
`default_nettype wire
